// ----- hw/rtl/tld_pkg.sv -----
package tld_pkg;

  parameter int unsigned WINDOW_DEF = 32;

  parameter logic signed [15:0] HEIGHT_THR_RESET = -16'sd180;
  parameter logic [31:0]        VAR_THR_RESET    = 32'd65536;

  typedef enum logic {
    REG_HEIGHT_THR = 1'b0,
    REG_VAR_THR    = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_TAKEOFF = 2'd1,
    EV_LANDING = 2'd2
  } event_e;

  typedef struct packed {
    logic valid;
    logic height_flag;
  } step_t;

endpackage

// ----- hw/rtl/tld_window.sv -----
module tld_window import tld_pkg::*; #(
  parameter int unsigned Window = WINDOW_DEF
) (
  input  logic        clk_i,
  input  logic        shift_i,
  input  logic [15:0] sample_i,
  output logic [15:0] oldest_o,
  output logic [31:0] oldest_sq_o
);

  logic [15:0] win_q [Window];
  logic [31:0] oldest_sq_q;

  // shift line: new sample enters at the top, oldest leaves at entry 0
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      for (int unsigned i = 0; i < Window - 1; i++) begin
        win_q[i] <= win_q[i + 1];
      end
      win_q[Window - 1] <= sample_i;
      oldest_sq_q       <= 32'(win_q[1]) * 32'(win_q[1]);
    end
  end

  assign oldest_o    = win_q[0];
  assign oldest_sq_o = oldest_sq_q;

endmodule

// ----- hw/rtl/tld_stats.sv -----
module tld_stats import tld_pkg::*; #(
  parameter int unsigned Window = WINDOW_DEF,
  localparam int unsigned CntW  = $clog2(Window + 1),
  localparam int unsigned SumW  = 16 + CntW,
  localparam int unsigned SqW   = 32 + CntW,
  localparam int unsigned CmpW  = 32 + 2 * CntW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  step_t           step_i,
  input  logic [15:0]     sample_i,
  input  logic [31:0]     sample_sq_i,
  input  logic [CmpW-1:0] rhs_i,
  output logic            motion_o
);

  logic [CntW-1:0] fill_q, fill_d;
  logic [SumW-1:0] sum_q, sum_d, sum_shift;
  logic [SqW-1:0]  sq_q, sq_d, sq_shift;
  logic            motion_q, motion_d;
  logic            full, upd, shift;
  logic [15:0]     oldest;
  logic [31:0]     oldest_sq;
  logic [CmpW-1:0] nq, ss, lhs;
  logic            reached;

  tld_window #(
    .Window(Window)
  ) u_window (
    .clk_i      (clk_i),
    .shift_i    (shift),
    .sample_i   (sample_i),
    .oldest_o   (oldest),
    .oldest_sq_o(oldest_sq)
  );

  assign full = (fill_q == CntW'(Window));
  assign upd  = !motion_q || !step_i.height_flag;

  assign sum_shift = SumW'((SumW + 1)'(sum_q) + (SumW + 1)'(sample_i)
                           - (SumW + 1)'(oldest));
  assign sq_shift  = SqW'((SqW + 1)'(sq_q) + (SqW + 1)'(sample_sq_i)
                          - (SqW + 1)'(oldest_sq));

  // N*Q - S*S >= thr*N*(N-1), rhs precomputed at config write
  assign nq      = CmpW'(sq_shift) * CmpW'(Window);
  assign ss      = CmpW'(sum_shift) * CmpW'(sum_shift);
  assign lhs     = (nq >= ss) ? (nq - ss) : '0;
  assign reached = (lhs >= rhs_i);

  always_comb begin
    fill_d   = fill_q;
    sum_d    = sum_q;
    sq_d     = sq_q;
    motion_d = motion_q;
    shift    = 1'b0;
    if (step_i.valid) begin
      if (upd) begin
        shift = 1'b1;
        if (!full) begin
          fill_d = fill_q + 1'b1;
          sum_d  = sum_q + SumW'(sample_i);
          sq_d   = sq_q + SqW'(sample_sq_i);
        end else begin
          sum_d    = sum_shift;
          sq_d     = sq_shift;
          motion_d = reached;
        end
      end else begin
        fill_d = '0;
        sum_d  = '0;
        sq_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      sum_q    <= '0;
      sq_q     <= '0;
      motion_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      sum_q    <= sum_d;
      sq_q     <= sq_d;
      motion_q <= motion_d;
    end
  end

  assign motion_o = motion_d;

endmodule

// ----- hw/rtl/takeoff_landing_detector.sv -----
// A request is taken into the input register, then its result into the result
// register as soon as that is empty or being read by the output side.
// Throughput: one request per cycle unless the output stalls; the running
// sum, sum of squares and variance compare update combinationally on each item.
// Reset (async, active low): clears handshake state, fill count, sums, motion
// and flying state, and loads the threshold defaults. Window contents stay
// undefined and are rewritten before use; there is no clearing pass.
module takeoff_landing_detector import tld_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // acc_magnitude[15:0], height_mm[31:16]

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // flying[0], event_res[2:1],
                                      // motion_flag[3], height_flag[4], zero[7:5]

  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned CntW     = $clog2(WINDOW + 1);
  localparam int unsigned CmpW     = 32 + 2 * CntW;
  localparam int unsigned VarScale = WINDOW * (WINDOW - 1);
  localparam logic [CmpW-1:0] RhsReset = CmpW'(VAR_THR_RESET) * CmpW'(VarScale);

  logic signed [15:0] hthr_q, hthr_d;
  logic [CmpW-1:0]    rhs_q, rhs_d;

  logic               in_valid_q, in_valid_d;
  logic [15:0]        acc_q;
  logic signed [15:0] height_q;
  logic [31:0]        acc_sq_q;

  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_data_q, out_data_d;
  logic               fly_q, fly_d;
  event_e             ev;

  logic               accept, advance, hflag, motion;
  step_t              step;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign hflag       = (height_q <= hthr_q);
  assign step.valid  = advance;
  assign step.height_flag = hflag;

  tld_stats #(
    .Window(WINDOW)
  ) u_stats (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .sample_i   (acc_q),
    .sample_sq_i(acc_sq_q),
    .rhs_i      (rhs_q),
    .motion_o   (motion)
  );

  always_comb begin
    hthr_d = hthr_q;
    rhs_d  = rhs_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HEIGHT_THR: hthr_d = $signed(cfg_wdata_i[15:0]);
        REG_VAR_THR:    rhs_d  = CmpW'(cfg_wdata_i) * CmpW'(VarScale);
        default:        ;
      endcase
    end
  end

  always_comb begin
    fly_d = fly_q;
    ev    = EV_NONE;
    if (motion && hflag && !fly_q) begin
      fly_d = 1'b1;
      ev    = EV_TAKEOFF;
    end else if (!motion && !hflag && fly_q) begin
      fly_d = 1'b0;
      ev    = EV_LANDING;
    end
    out_data_d = {3'b000, hflag, motion, ev, fly_d};
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hthr_q      <= HEIGHT_THR_RESET;
      rhs_q       <= RhsReset;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fly_q       <= 1'b0;
    end else begin
      hthr_q      <= hthr_d;
      rhs_q       <= rhs_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        fly_q <= fly_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q    <= s_axis_tdata[15:0];
      height_q <= $signed(s_axis_tdata[31:16]);
      acc_sq_q <= 32'(s_axis_tdata[15:0]) * 32'(s_axis_tdata[15:0]);
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- test/tb_takeoff_landing_detector.sv -----
`timescale 1ns / 100ps

module tb_takeoff_landing_detector;
  import tld_pkg::*;

  localparam int unsigned WIN_LEN     = WINDOW_DEF;
  localparam int          CYCLE_LIMIT = 300000;
  localparam int          PHASE_ITEMS = 220;
  localparam int          NUM_PHASES  = 5;

  typedef struct packed {
    logic   height_flag;
    logic   motion;
    event_e ev;
    logic   flying;
  } flight_status_t;

  typedef enum {
    K_GROUND_QUIET,
    K_GROUND_SHAKE,
    K_AIR_QUIET,
    K_AIR_SHAKE,
    K_NOISE
  } item_kind_e;

  class flight_scoreboard;
    logic [15:0]        win [WIN_LEN];
    int unsigned        fill_cnt;
    longint unsigned    acc_sum;
    longint unsigned    acc_sumsq;
    bit                 motion;
    bit                 flying;
    logic signed [15:0] height_thr;
    logic [31:0]        var_thr;
    flight_status_t     expected_q[$];
    int                 errors;
    int                 takeoffs;
    int                 landings;

    function new();
      height_thr = HEIGHT_THR_RESET;
      var_thr    = VAR_THR_RESET;
      fill_cnt   = 0;
      acc_sum    = 0;
      acc_sumsq  = 0;
      motion     = 1'b0;
      flying     = 1'b0;
      errors     = 0;
      takeoffs   = 0;
      landings   = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [31:0] val);
      case (idx)
        REG_HEIGHT_THR: height_thr = val[15:0];
        REG_VAR_THR:    var_thr    = val;
        default: ;
      endcase
    endfunction

    function bit variance_high();
      longint unsigned lhs_a;
      longint unsigned lhs_b;
      longint unsigned lhs;
      longint unsigned rhs;
      lhs_a = 64'(WIN_LEN) * acc_sumsq;
      lhs_b = acc_sum * acc_sum;
      lhs   = (lhs_a >= lhs_b) ? lhs_a - lhs_b : 64'd0;
      rhs   = 64'(var_thr) * 64'(WIN_LEN) * 64'(WIN_LEN - 1);
      return lhs >= rhs;
    endfunction

    function void note_request(logic [15:0] acc, logic signed [15:0] height);
      flight_status_t  st;
      bit              hflag;
      longint unsigned old_s;
      longint unsigned new_s;
      hflag = (height <= height_thr);
      new_s = 64'(acc);
      st.ev = EV_NONE;
      if (!motion || !hflag) begin
        if (fill_cnt < WIN_LEN) begin
          win[fill_cnt] = acc;
          fill_cnt++;
          acc_sum   += new_s;
          acc_sumsq += new_s * new_s;
        end else begin
          old_s = 64'(win[0]);
          for (int i = 0; i < WIN_LEN - 1; i++) win[i] = win[i + 1];
          win[WIN_LEN - 1] = acc;
          acc_sum   = acc_sum - old_s + new_s;
          acc_sumsq = acc_sumsq - old_s * old_s + new_s * new_s;
          motion    = variance_high();
        end
      end else begin
        // airborne and moving: drop sample, restart window
        fill_cnt  = 0;
        acc_sum   = 0;
        acc_sumsq = 0;
      end
      if (motion && hflag && !flying) begin
        flying = 1'b1;
        st.ev  = EV_TAKEOFF;
      end else if (!motion && !hflag && flying) begin
        flying = 1'b0;
        st.ev  = EV_LANDING;
      end
      st.flying      = flying;
      st.motion      = motion;
      st.height_flag = hflag;
      expected_q.push_back(st);
    endfunction

    function void check_result(logic [7:0] data);
      flight_status_t want;
      if (expected_q.size() == 0) begin
        $error("result with no pending request: data %h", data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (data[0] !== want.flying) begin
        $error("flying: expected %0d, actual %0d", want.flying, data[0]);
        errors++;
      end
      if (data[2:1] !== want.ev) begin
        $error("event_res: expected %0d, actual %0d", want.ev, data[2:1]);
        errors++;
      end
      if (data[3] !== want.motion) begin
        $error("motion_flag: expected %0d, actual %0d", want.motion, data[3]);
        errors++;
      end
      if (data[4] !== want.height_flag) begin
        $error("height_flag: expected %0d, actual %0d", want.height_flag, data[4]);
        errors++;
      end
      if (data[7:5] !== 3'b000) begin
        $error("pad bits: expected 0, actual %0d", data[7:5]);
        errors++;
      end
      if (want.ev == EV_TAKEOFF) takeoffs++;
      if (want.ev == EV_LANDING) landings++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  flight_scoreboard sb;
  bit               no_idle;
  bit               hold_req;
  int               cycle_cnt;
  int               sent_cnt;

  takeoff_landing_detector dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  // requests are noted before results are checked within the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_request(s_axis_tdata[15:0], s_axis_tdata[31:16]);
        sent_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_req = 1'b0;
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= 12);
    end
  end

  task automatic send_request(logic [15:0] acc, logic signed [15:0] height);
    while (!no_idle && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {height, acc};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_acc(bit shaky, int base);
    int v;
    int amp;
    if (shaky && $urandom_range(3) == 0) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    amp = shaky ? 3000 + int'($urandom_range(20000)) : int'($urandom_range(24));
    v = base + int'($urandom_range(2 * amp)) - amp;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] pick_height(bit air);
    int thr;
    int lo;
    int hi;
    int r;
    thr = sb.height_thr;
    r   = $urandom_range(9);
    if (air) begin
      lo = -32768;
      hi = thr;
    end else begin
      lo = thr + 1;
      hi = 32767;
    end
    if (r == 0) return air ? 16'(thr) : 16'(thr + 1);
    if (r < 5) begin
      if (air && lo < thr - 300) lo = thr - 300;
      if (!air && hi > thr + 300) hi = thr + 300;
    end
    return 16'(lo + int'($urandom_range(hi - lo)));
  endfunction

  task automatic send_kind(item_kind_e kind, int n, int base);
    for (int i = 0; i < n; i++) begin
      case (kind)
        K_GROUND_QUIET: send_request(pick_acc(1'b0, base), pick_height(1'b0));
        K_GROUND_SHAKE: send_request(pick_acc(1'b1, base), pick_height(1'b0));
        K_AIR_QUIET:    send_request(pick_acc(1'b0, base), pick_height(1'b1));
        K_AIR_SHAKE:    send_request(pick_acc(1'b1, base), pick_height(1'b1));
        default:        send_request(16'($urandom_range(65535)), 16'($urandom_range(65535)));
      endcase
    end
  endtask

  task automatic run_phase(int n_items);
    int start;
    int base;
    int r;
    start = sent_cnt;
    while (sent_cnt - start < n_items) begin
      base = 1500 + $urandom_range(2000);
      r    = $urandom_range(99);
      if (r < 65) begin
        // ground, spin-up, climb, optional bounce, settle
        send_kind(K_GROUND_QUIET, 34 + $urandom_range(16), base);
        send_kind(K_GROUND_SHAKE, 4 + $urandom_range(16), base);
        send_kind($urandom_range(1) ? K_AIR_SHAKE : K_AIR_QUIET, 3 + $urandom_range(30), base);
        if ($urandom_range(2) == 0) begin
          send_kind(K_GROUND_SHAKE, 1 + $urandom_range(4), base);
          send_kind(K_AIR_QUIET, 3 + $urandom_range(7), base);
        end
        send_kind(K_GROUND_QUIET, 36 + $urandom_range(30), base);
      end else if (r < 80) begin
        send_kind(K_NOISE, 3 + $urandom_range(20), base);
      end else begin
        repeat (2 + $urandom_range(4))
          send_kind(item_kind_e'($urandom_range(4)), 1 + $urandom_range(39), base);
      end
    end
  endtask

  initial begin
    logic signed [15:0] h_set;
    logic [31:0]        v_set;
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_HEIGHT_THR;
    cfg_wdata_i   = '0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    cycle_cnt     = 0;
    sent_cnt      = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // field extremes and height threshold boundary
    send_request(16'h0000, 16'sh7FFF);
    send_request(16'hFFFF, 16'sh8000);
    send_request(16'h5555, -16'sd180);
    send_request(16'hAAAA, -16'sd179);
    send_request(16'h0001, 16'sh0000);
    send_request(16'h8000, -16'sd1);
    send_request(16'h7FFF, 16'sh5555);
    send_request(16'hFFFF, -16'sd181);
    send_request(16'h0000, 16'shAAAA);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin h_set = HEIGHT_THR_RESET; v_set = VAR_THR_RESET; end
        1: begin h_set = 16'sh0000;        v_set = 32'd0;          end
        2: begin h_set = 16'sh8000;        v_set = 32'hFFFF_FFFF;  end
        3: begin h_set = -16'sd500;        v_set = 32'h0010_0000;  end
        default: begin h_set = HEIGHT_THR_RESET; v_set = 32'd4096; end
      endcase
      write_reg(REG_HEIGHT_THR, 32'(h_set));
      write_reg(REG_VAR_THR, v_set);
      no_idle = (ph == 3);
      if (ph == NUM_PHASES - 1) hold_req = 1'b1;
      run_phase(PHASE_ITEMS);
      drain();
    end
    no_idle = 1'b0;
    repeat (8) @(negedge clk_i);

    $display("Covered %0d requests across %0d threshold settings, incl. a long output stall.",
             sent_cnt, NUM_PHASES);
    $display("Saw %0d takeoffs and %0d landings; %0d mismatches.",
             sb.takeoffs, sb.landings, sb.errors);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tld_pkg.sv
hw/rtl/tld_window.sv
hw/rtl/tld_stats.sv
hw/rtl/takeoff_landing_detector.sv
test/tb_takeoff_landing_detector.sv
